@@ hdl/rmf_pkg.sv @@
// ----------------------------------------------------------------------------
// rmf_pkg: shared types and constants of the running median filter
// Window depth, derived widths, controller states and the command/status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package rmf_pkg;

   localparam int WINDOW_MAX = 16;
   localparam int SAMPLE_W   = 16;
   localparam int CSR_W      = 5;
   localparam int OUT_CNT_W  = 5;
   localparam int SLOT_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int COUNT_W    = $clog2(WINDOW_MAX + 1);

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_REMOVE  = 5'b00010,
      ST_INSERT  = 5'b00100,
      ST_PICK_LO = 5'b01000,
      ST_PICK_HI = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;      // capture an input beat
      logic remove;    // drop the oldest sample from the sorted list
      logic insert;    // insert the new sample, write the ring
      logic pick_lo;   // register the lower middle value
      logic pick_hi;   // form the median into the output register
   } cmd_type;

   typedef struct packed {
      logic full;      // fill count has reached the window length
   } status_type;

endpackage

@@ hdl/running_median_filter.sv @@
// ----------------------------------------------------------------------------
// running_median_filter: sliding-window median of signed 16-bit samples
// Median over the last window_length samples (fewer until the window fills),
// the two middle values floor-averaged for an even count.
// ----------------------------------------------------------------------------
//  channel   ports                                     direction
//  req       req_valid/ready, req_sample, req_restart  in
//  rsp       rsp_valid/ready, rsp_median,              out
//            rsp_window_count
//  csr       csr_we, csr_wdata (window_length)         in
//
//  An item steps through accept, remove oldest, insert and two median picks,
//  as the sequencer edits the sorted register list one step at a time.
//  The next beat is accepted once the median is in the output register.
//  A result waiting on rsp_ready holds only the last pick step.
//  Synchronous active-high reset; window_length resets to 16, window empty.
// ----------------------------------------------------------------------------
module running_median_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [rmf_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [rmf_pkg::SAMPLE_W-1:0]  rsp_median,
   output logic        [rmf_pkg::OUT_CNT_W-1:0] rsp_window_count,
   input  logic                                 csr_we,
   input  logic        [rmf_pkg::CSR_W-1:0]     csr_wdata
);

   rmf_pkg::cmd_type    cmd;
   rmf_pkg::status_type status;

   rmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rmf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample       (req_sample),
      .req_restart      (req_restart),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rsp_median       (rsp_median),
      .rsp_window_count (rsp_window_count)
   );

endmodule

@@ hdl/rmf_ctrl.sv @@
// ----------------------------------------------------------------------------
// rmf_ctrl: sequencer of the running median filter
// Steps each beat through remove, insert and the two median picks, and owns
// the result valid flag.
// ----------------------------------------------------------------------------
module rmf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  rmf_pkg::status_type status,
   output rmf_pkg::cmd_type    cmd
);

   rmf_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign req_ready = (state_ff == rmf_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      case (state_ff)
         rmf_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rmf_pkg::ST_REMOVE;
            end
         end
         rmf_pkg::ST_REMOVE: begin
            cmd.remove = status.full;
            state_in   = rmf_pkg::ST_INSERT;
         end
         rmf_pkg::ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = rmf_pkg::ST_PICK_LO;
         end
         rmf_pkg::ST_PICK_LO: begin
            cmd.pick_lo = 1'b1;
            state_in    = rmf_pkg::ST_PICK_HI;
         end
         rmf_pkg::ST_PICK_HI: begin
            // hold here while the previous result is still unclaimed
            if (out_free) begin
               cmd.pick_hi = 1'b1;
               state_in    = rmf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rmf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.pick_hi) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmf_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ hdl/rmf_datapath.sv @@
// ----------------------------------------------------------------------------
// rmf_datapath: sample ring, sorted window and median arithmetic
// Keeps the window both in arrival order (ring) and sorted; the sorted list
// is updated by a parallel compare-and-shift per step.
// ----------------------------------------------------------------------------
module rmf_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  rmf_pkg::cmd_type                        cmd,
   output rmf_pkg::status_type                     status,
   input  logic signed [rmf_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                                    req_restart,
   input  logic                                    csr_we,
   input  logic        [rmf_pkg::CSR_W-1:0]        csr_wdata,
   output logic signed [rmf_pkg::SAMPLE_W-1:0]     rsp_median,
   output logic        [rmf_pkg::OUT_CNT_W-1:0]    rsp_window_count
);

   logic        [rmf_pkg::COUNT_W-1:0]  window_ff, window_in;
   logic        [rmf_pkg::COUNT_W-1:0]  fill_ff, fill_in;
   logic        [rmf_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic signed [rmf_pkg::SAMPLE_W-1:0] sample_ff;
   logic signed [rmf_pkg::SAMPLE_W-1:0] lo_ff;
   logic signed [rmf_pkg::SAMPLE_W-1:0] median_ff;
   logic        [rmf_pkg::COUNT_W-1:0]  count_ff;
   logic signed [rmf_pkg::SAMPLE_W-1:0] ring_ff   [rmf_pkg::WINDOW_MAX];
   logic signed [rmf_pkg::SAMPLE_W-1:0] sorted_ff [rmf_pkg::WINDOW_MAX];
   logic signed [rmf_pkg::SAMPLE_W-1:0] sorted_in [rmf_pkg::WINDOW_MAX];
   logic        [rmf_pkg::WINDOW_MAX-1:0] keep_low;
   logic        [rmf_pkg::WINDOW_MAX-1:0] above;
   logic signed [rmf_pkg::SAMPLE_W-1:0] oldest_ff;
   logic signed [rmf_pkg::SAMPLE_W-1:0] hi_pick;
   logic signed [rmf_pkg::SAMPLE_W:0]   pair_sum;
   logic        [rmf_pkg::COUNT_W-1:0]  slot_next;
   logic        [rmf_pkg::COUNT_W-1:0]  csr_clamped;
   logic        [rmf_pkg::COUNT_W:0]    csr_wide;

   assign status.full = (fill_ff == window_ff);

   // zero acts as one, anything beyond the depth as the depth
   assign csr_wide = (rmf_pkg::COUNT_W + 1)'(csr_wdata);
   always_comb begin
      if (csr_wdata == '0) begin
         csr_clamped = rmf_pkg::COUNT_W'(1);
      end else if (csr_wide > (rmf_pkg::COUNT_W + 1)'(rmf_pkg::WINDOW_MAX)) begin
         csr_clamped = rmf_pkg::COUNT_W'(rmf_pkg::WINDOW_MAX);
      end else begin
         csr_clamped = csr_wide[rmf_pkg::COUNT_W-1:0];
      end
   end

   assign slot_next = rmf_pkg::COUNT_W'(slot_ff) + rmf_pkg::COUNT_W'(1);

   // Remove: the oldest value sits just after every entry below it, so all
   // entries not below it move down one place. Insert: entries above the new
   // value (or past the fill) move up; the first of them takes the new value.
   always_comb begin
      for (int k = 0; k < rmf_pkg::WINDOW_MAX; k++) begin
         keep_low[k] = sorted_ff[k] < oldest_ff;
         above[k]    = (rmf_pkg::COUNT_W'(k) >= fill_ff) || (sorted_ff[k] > sample_ff);
      end
      for (int k = 0; k < rmf_pkg::WINDOW_MAX; k++) begin
         sorted_in[k] = sorted_ff[k];
      end
      if (cmd.remove) begin
         for (int k = 0; k < rmf_pkg::WINDOW_MAX - 1; k++) begin
            if (!keep_low[k]) begin
               sorted_in[k] = sorted_ff[k+1];
            end
         end
      end else if (cmd.insert) begin
         if (above[0]) begin
            sorted_in[0] = sample_ff;
         end
         for (int k = 1; k < rmf_pkg::WINDOW_MAX; k++) begin
            if (above[k]) begin
               sorted_in[k] = above[k-1] ? sorted_ff[k-1] : sample_ff;
            end
         end
      end
   end

   // floor of the mean; for an odd count both picks are the same entry
   assign hi_pick  = sorted_ff[rmf_pkg::SLOT_W'(fill_ff >> 1)];
   assign pair_sum = (rmf_pkg::SAMPLE_W + 1)'(lo_ff) + (rmf_pkg::SAMPLE_W + 1)'(hi_pick);

   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      slot_in   = slot_ff;
      if (csr_we) begin
         window_in = csr_clamped;
         fill_in   = '0;
         slot_in   = '0;
      end else if (cmd.load) begin
         if (req_restart) begin
            fill_in = '0;
            slot_in = '0;
         end
      end else if (cmd.remove) begin
         fill_in = fill_ff - rmf_pkg::COUNT_W'(1);
      end else if (cmd.insert) begin
         fill_in = fill_ff + rmf_pkg::COUNT_W'(1);
         slot_in = (slot_next >= window_ff) ? '0 : slot_next[rmf_pkg::SLOT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= rmf_pkg::COUNT_W'(rmf_pkg::WINDOW_MAX);
         fill_ff   <= '0;
         slot_ff   <= '0;
      end else begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
         slot_ff   <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= req_sample;
         // slot about to be overwritten; only used when the window is full
         oldest_ff <= ring_ff[slot_ff];
      end
      if (cmd.insert) begin
         ring_ff[slot_ff] <= sample_ff;
      end
      sorted_ff <= sorted_in;
      if (cmd.pick_lo) begin
         lo_ff <= sorted_ff[rmf_pkg::SLOT_W'((fill_ff - rmf_pkg::COUNT_W'(1)) >> 1)];
      end
      if (cmd.pick_hi) begin
         median_ff <= pair_sum[rmf_pkg::SAMPLE_W:1];
         count_ff  <= fill_ff;
      end
   end

   assign rsp_median       = median_ff;
   assign rsp_window_count = rmf_pkg::OUT_CNT_W'(count_ff);

endmodule

@@ hdl/rmf_checker.sv @@
// ----------------------------------------------------------------------------
// rmf_checker: port-level checks on the running median filter
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module rmf_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [rmf_pkg::SAMPLE_W-1:0]  rsp_median,
   input logic        [rmf_pkg::OUT_CNT_W-1:0] rsp_window_count
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median)
                                  && $stable(rsp_window_count))
      else $error("result beat changed while stalled");

   // one beat in flight: no accept straight after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a beat is in progress");

   // a new result appears only from the final pick step
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a beat in progress");

   // count never empty, never past the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_window_count != '0
                    && rsp_window_count <= rmf_pkg::OUT_CNT_W'(rmf_pkg::WINDOW_MAX))
      else $error("window count out of range");

endmodule

bind running_median_filter rmf_checker u_rmf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_median       (rsp_median),
   .rsp_window_count (rsp_window_count)
);
